[src/ple_pkg.sv]
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

   // Field widths of the request and response transactions
   localparam int KIND_W = 2;
   localparam int POS_W = 7;
   localparam int VAL_W = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W = 7;
   localparam int REQ_PAD_W = 1;
   localparam int REQ_DATA_W = POS_W + VAL_W + REQ_PAD_W;
   localparam int RSP_PAD_W = 2;
   localparam int RSP_DATA_W = LEN_W + VAL_W + LEN_W + RSP_PAD_W;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd2;

   // Response status codes
   localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic              load;       // capture the accepted request
      logic              step;       // issue one memory read and advance the index
      logic              ins_write;  // write the inserted value at its slot
      logic              emit;       // load the response register, commit length
      logic [STAT_W-1:0] status;     // status code reported on emit
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              ins_range;
      logic              ins_full;
      logic              del_range;
      logic              more;       // index has entries left to visit
      logic              pend;       // a read is in flight
      logic              hit;        // locate found a match
      logic              out_free;   // response register can take a result
   } dp_stat_type;

endpackage

`default_nettype wire

[src/ple_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/ple_ctrl.sv]
// Controller state machine that sequences insert, delete and locate requests.
`default_nettype none

module ple_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire ple_pkg::dp_stat_type stat,
   output ple_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_SHIFT,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [ple_pkg::STAT_W-1:0]   res_ff, res_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      res_in        = res_ff;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.ins_write = 1'b0;
      cmd.emit      = 1'b0;
      cmd.status    = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (stat.kind)
               ple_pkg::KIND_INSERT: begin
                  if (stat.ins_range) begin
                     res_in   = ple_pkg::STAT_RANGE;
                     state_in = S_DONE;
                  end else if (stat.ins_full) begin
                     res_in   = ple_pkg::STAT_FULL;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_INS_SHIFT;
                  end
               end
               ple_pkg::KIND_DELETE: begin
                  if (stat.del_range) begin
                     res_in   = ple_pkg::STAT_RANGE;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_DEL_SHIFT;
                  end
               end
               ple_pkg::KIND_LOCATE: begin
                  state_in = S_SCAN;
               end
               default: begin
                  res_in   = ple_pkg::STAT_OK;
                  state_in = S_DONE;
               end
            endcase
         end
         S_INS_SHIFT: begin
            cmd.step = stat.more;
            if (!stat.more && !stat.pend) begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            cmd.ins_write = 1'b1;
            res_in        = ple_pkg::STAT_OK;
            state_in      = S_DONE;
         end
         S_DEL_SHIFT: begin
            cmd.step = stat.more;
            if (!stat.more && !stat.pend) begin
               res_in   = ple_pkg::STAT_OK;
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.step = stat.more && !stat.hit;
            if (!stat.pend && (stat.hit || !stat.more)) begin
               res_in   = stat.hit ? ple_pkg::STAT_OK : ple_pkg::STAT_MISSING;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the pending result code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= ple_pkg::STAT_OK;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

endmodule

`default_nettype wire

[src/ple_dp.sv]
// Datapath: entry memory, shift and scan index, length and response register.
`default_nettype none

module ple_dp #(
   parameter int CAPACITY = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ple_pkg::ctl_cmd_type               cmd,
   output ple_pkg::dp_stat_type                    stat,
   input  wire logic [ple_pkg::KIND_W-1:0]         req_tuser,
   input  wire logic [ple_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [ple_pkg::STAT_W-1:0]         rsp_tuser,
   output logic      [ple_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
   localparam int PW = ple_pkg::POS_W;
   localparam int VW = ple_pkg::VAL_W;
   localparam int LW = ple_pkg::LEN_W;

   // Request capture
   logic [ple_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [VW-1:0]              val_ff, val_in;

   // List state and walk
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [CW-1:0]              pa_ff, pa_in;
   logic                       pv_ff, pv_in;
   logic                       hit_ff, hit_in;
   logic [CW-1:0]              found_ff, found_in;
   logic [VW-1:0]              removed_ff, removed_in;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [LW-1:0]              rsp_found_ff, rsp_found_in;
   logic [VW-1:0]              rsp_removed_ff, rsp_removed_in;
   logic [LW-1:0]              rsp_length_ff, rsp_length_in;

   // Extended views for compares
   logic [XW-1:0] pos_x, count_x, k_x, pos_m1_x, found_x, next_count_x;
   logic [CW-1:0] k_dec, pa_dec, next_count;
   logic          is_insert, is_delete, is_locate;

   // Memory port
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [VW-1:0] mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [VW-1:0] mem_rd_data;

   assign is_insert = (kind_ff == ple_pkg::KIND_INSERT);
   assign is_delete = (kind_ff == ple_pkg::KIND_DELETE);
   assign is_locate = (kind_ff == ple_pkg::KIND_LOCATE);

   assign pos_x    = XW'(pos_ff);
   assign count_x  = XW'(count_ff);
   assign k_x      = XW'(k_ff);
   assign pos_m1_x = pos_x - XW'(1);
   assign found_x  = XW'(found_ff);
   assign k_dec    = k_ff - CW'(1);
   assign pa_dec   = pa_ff - CW'(1);

   // Status toward the controller
   assign stat.kind      = kind_ff;
   assign stat.ins_range = (pos_x == '0) || (pos_x > count_x + XW'(1));
   assign stat.ins_full  = (count_x == XW'(CAPACITY));
   assign stat.del_range = (pos_x == '0) || (pos_x > count_x);
   assign stat.more      = is_insert ? (k_x >= pos_x) : (k_x < count_x);
   assign stat.pend      = pv_ff;
   assign stat.hit       = hit_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // Read address: walk down for insert, up for delete and locate
   assign mem_rd_addr = is_insert ? k_dec[AW-1:0] : k_ff[AW-1:0];

   // Write port: inserted value, or the entry whose read was issued in the previous cycle
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = pa_ff[AW-1:0];
      mem_wr_data = mem_rd_data;
      if (cmd.ins_write) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = pos_m1_x[AW-1:0];
         mem_wr_data = val_ff;
      end else if (pv_ff && is_insert) begin
         mem_wr_en = 1'b1;
      end else if (pv_ff && is_delete && (pa_ff != pos_m1_x[CW-1:0])) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = pa_dec[AW-1:0];
      end
   end

   ple_ram #(
      .WIDTH (VW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (cmd.step),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Length after a successful insert or delete
   always_comb begin
      next_count = count_ff;
      if (cmd.status == ple_pkg::STAT_OK) begin
         if (is_insert) begin
            next_count = count_ff + CW'(1);
         end else if (is_delete) begin
            next_count = count_ff - CW'(1);
         end
      end
   end
   assign next_count_x = XW'(next_count);

   // Next values
   always_comb begin
      kind_in        = kind_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      pa_in          = pa_ff;
      pv_in          = cmd.step;
      hit_in         = hit_ff;
      found_in       = found_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_length_in  = rsp_length_ff;

      // Capture the transaction and set the start index
      if (cmd.load) begin
         kind_in    = req_tuser;
         pos_in     = req_tdata[PW-1:0];
         val_in     = req_tdata[PW+VW-1:PW];
         hit_in     = 1'b0;
         found_in   = '0;
         removed_in = '0;
         case (req_tuser)
            ple_pkg::KIND_INSERT: k_in = count_ff;
            ple_pkg::KIND_DELETE: k_in = CW'(XW'(req_tdata[PW-1:0]) - XW'(1));
            default:              k_in = '0;
         endcase
      end

      // Advance the walk
      if (cmd.step) begin
         pa_in = k_ff;
         k_in  = is_insert ? k_dec : (k_ff + CW'(1));
      end

      // Consume the read data
      if (pv_ff) begin
         if (is_delete && (pa_ff == pos_m1_x[CW-1:0])) begin
            removed_in = mem_rd_data;
         end
         if (is_locate && !hit_ff && (mem_rd_data == val_ff)) begin
            hit_in   = 1'b1;
            found_in = pa_ff + CW'(1);
         end
      end

      // Publish the result and commit the length
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = cmd.status;
         rsp_found_in   = (is_locate && hit_ff) ? found_x[LW-1:0] : '0;
         rsp_removed_in = (is_delete && cmd.status == ple_pkg::STAT_OK) ? removed_ff : '0;
         rsp_length_in  = next_count_x[LW-1:0];
         count_in       = next_count;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pv_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      k_ff           <= k_in;
      pa_ff          <= pa_in;
      found_ff       <= found_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_length_ff  <= rsp_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{ple_pkg::RSP_PAD_W{1'b0}}, rsp_length_ff, rsp_removed_ff,
                        rsp_found_ff};

endmodule

`default_nettype wire

[src/positional_list_engine_core.sv]
// Top level of the positional list engine: controller plus datapath.
//
// Holds an ordered list of up to CAPACITY signed 32-bit entries addressed by
// 1-based position. Each request transaction on the req_ channel is insert,
// delete or locate (req_tuser); each produces exactly one response
// transaction on the rsp_ channel with a status (rsp_tuser), the found
// position, the removed value and the list length after the request.
// One request is worked on at a time. Delete and locate read entries in turn
// and insert moves them, one entry per cycle, as the entry memory has one read
// and one write port; insert then writes its value. Locate on an empty list
// reads no entry, and rejected and reserved requests skip the walk. The next
// request can be taken in the cycle after a response is loaded.
// The response sits in an output register: req_tready returns as soon as the
// result is loaded there, so the next request is taken while the receiver
// stalls; a finished result then waits until the register frees.
// Reset empties the list (length zero) at once; the entry memory is not
// cleared, since only entries below the length are ever read.
`default_nettype none

module positional_list_engine_core #(
   parameter int CAPACITY = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // req_type[1:0]
   input  wire logic [ple_pkg::KIND_W-1:0]         req_tuser,
   // position[6:0], item_value[38:7], zero pad[39]
   input  wire logic [ple_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // status[1:0]
   output logic      [ple_pkg::STAT_W-1:0]         rsp_tuser,
   // found_position[6:0], removed_value[38:7], list_length[45:39], pad[47:46]
   output logic      [ple_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   ple_pkg::ctl_cmd_type cmd;
   ple_pkg::dp_stat_type stat;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ple_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[sim/positional_list_engine_core_test.sv]
// Self-checking random testbench for the positional list engine, with its own list predictor.
`timescale 1ns / 100ps

module positional_list_engine_core_test;

   localparam int LIST_DEPTH = 64;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = LIST_DEPTH + 10;
   localparam logic [ple_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;

   typedef struct packed {
      logic [ple_pkg::KIND_W-1:0] kind;
      logic [ple_pkg::POS_W-1:0]  pos;
      logic [ple_pkg::VAL_W-1:0]  value;
   } list_request_type;

   typedef struct packed {
      logic [ple_pkg::STAT_W-1:0] status;
      logic [ple_pkg::POS_W-1:0]  found;
      logic [ple_pkg::VAL_W-1:0]  removed;
      logic [ple_pkg::LEN_W-1:0]  length;
   } list_result_type;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} phase_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ple_pkg::KIND_W-1:0] req_tuser = '0;
   logic [ple_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ple_pkg::STAT_W-1:0] rsp_tuser;
   logic [ple_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // Predictor state: shadow copy of the list
   logic [ple_pkg::VAL_W-1:0] shadow_entries [LIST_DEPTH];
   int shadow_len = 0;

   list_request_type pending_reqs[$];
   list_result_type predicted_results[$];
   list_request_type active_req;

   int cycle_count = 0;
   int error_count = 0;
   int gen_len = 0;
   int send_gap = 0;
   int stall_left = 0;
   int kind_count [4] = '{0, 0, 0, 0};
   int status_count [4] = '{0, 0, 0, 0};
   int results_checked = 0;
   int peak_len = 0;

   positional_list_engine_core #(.CAPACITY(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Calm windows: the driver inserts no gaps and the monitor starts no new stalls here
   function automatic bit calm_window();
      return (cycle_count % 1024) < 200;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ple_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return 32'h0000_002A;
         default: return $urandom;
      endcase
   endfunction

   // Queue a request and track the length it leaves behind, for stimulus shaping
   function automatic void queue_request(logic [ple_pkg::KIND_W-1:0] kind, int pos,
                                         logic [ple_pkg::VAL_W-1:0] value);
      list_request_type req;
      req.kind = kind;
      req.pos = pos[ple_pkg::POS_W-1:0];
      req.value = value;
      pending_reqs.push_back(req);
      if (kind == ple_pkg::KIND_INSERT && pos >= 1 && pos <= gen_len + 1 &&
          gen_len < LIST_DEPTH)
         gen_len++;
      else if (kind == ple_pkg::KIND_DELETE && pos >= 1 && pos <= gen_len)
         gen_len--;
   endfunction

   // Work out the response of one request and update the shadow list
   function automatic list_result_type apply_list_request(list_request_type req);
      list_result_type res;
      int pos;
      int k;
      int found_pos;
      res = '0;
      res.status = ple_pkg::STAT_OK;
      pos = req.pos;
      case (req.kind)
         ple_pkg::KIND_INSERT: begin
            if (pos < 1 || pos > shadow_len + 1) begin
               res.status = ple_pkg::STAT_RANGE;
            end else if (shadow_len >= LIST_DEPTH) begin
               res.status = ple_pkg::STAT_FULL;
            end else begin
               for (k = shadow_len; k >= pos; k--) shadow_entries[k] = shadow_entries[k-1];
               shadow_entries[pos-1] = req.value;
               shadow_len++;
            end
         end
         ple_pkg::KIND_DELETE: begin
            if (pos < 1 || pos > shadow_len) begin
               res.status = ple_pkg::STAT_RANGE;
            end else begin
               res.removed = shadow_entries[pos-1];
               for (k = pos; k < shadow_len; k++) shadow_entries[k-1] = shadow_entries[k];
               shadow_len--;
            end
         end
         ple_pkg::KIND_LOCATE: begin
            res.status = ple_pkg::STAT_MISSING;
            for (k = 0; k < shadow_len; k++) begin
               if (res.status == ple_pkg::STAT_MISSING && shadow_entries[k] == req.value) begin
                  res.status = ple_pkg::STAT_OK;
                  found_pos = k + 1;
                  res.found = found_pos[ple_pkg::POS_W-1:0];
               end
            end
         end
         default: ;
      endcase
      res.length = shadow_len[ple_pkg::LEN_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      $display("[%0t] mismatch #%0d: %s", $realtime, error_count, msg);
   endtask

   // Request driver: predict on each accepted transaction, then launch the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(apply_list_request(active_req));
            kind_count[active_req.kind]++;
            if (shadow_len > peak_len) peak_len = shadow_len;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 && !calm_window()) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               active_req = pending_reqs.pop_front();
               req_tuser <= active_req.kind;
               req_tdata <= {{ple_pkg::REQ_PAD_W{1'b0}}, active_req.value, active_req.pos};
               req_tvalid <= 1'b1;
               send_gap = ($urandom_range(0, 1) == 0) ? 0 : pick_idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted transaction, stall at random
   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.found = rsp_tdata[6:0];
            got.removed = rsp_tdata[38:7];
            got.length = rsp_tdata[45:39];
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("response with none outstanding, data %h",
                                         rsp_tdata));
            end else begin
               want = predicted_results.pop_front();
               results_checked++;
               status_count[got.status]++;
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
               if (got.found !== want.found)
                  report_mismatch($sformatf("found_position %0d, want %0d", got.found, want.found));
               if (got.removed !== want.removed)
                  report_mismatch($sformatf("removed_value %h, want %h", got.removed, want.removed));
               if (got.length !== want.length)
                  report_mismatch($sformatf("list_length %0d, want %0d", got.length, want.length));
            end
         end
         if (stall_left == 0 && !calm_window() && $urandom_range(0, 7) == 0)
            stall_left = pick_idle_len();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus, end of run and verdict
   initial begin
      phase_mode_type mode;
      int target;
      int tail_left;
      int phase_items;
      int ins_pct;
      int del_pct;
      int r;
      int pos;
      bit done;
      logic [ple_pkg::KIND_W-1:0] kind;
      logic [ple_pkg::VAL_W-1:0] value;

      // Directed: empty-list errors, extremes, duplicates, reserved kind
      queue_request(ple_pkg::KIND_INSERT, 0, 32'h1);
      queue_request(ple_pkg::KIND_INSERT, 2, 32'h2);
      queue_request(ple_pkg::KIND_DELETE, 1, 32'h0);
      queue_request(ple_pkg::KIND_LOCATE, 0, 32'h0);
      queue_request(KIND_RESERVED, 127, 32'hFFFF_FFFF);
      queue_request(ple_pkg::KIND_INSERT, 1, 32'h7FFF_FFFF);
      queue_request(ple_pkg::KIND_INSERT, 1, 32'h8000_0000);
      queue_request(ple_pkg::KIND_INSERT, 3, 32'h0000_0000);
      queue_request(ple_pkg::KIND_INSERT, 2, 32'hFFFF_FFFF);
      queue_request(ple_pkg::KIND_INSERT, 127, 32'h5);
      queue_request(ple_pkg::KIND_LOCATE, 127, 32'h8000_0000);
      queue_request(ple_pkg::KIND_LOCATE, 0, 32'h0000_0000);
      queue_request(ple_pkg::KIND_LOCATE, 5, 32'hFFFF_FFFF);
      queue_request(ple_pkg::KIND_LOCATE, 1, 32'h1234_5678);
      queue_request(ple_pkg::KIND_INSERT, 1, 32'h5);
      queue_request(ple_pkg::KIND_INSERT, 6, 32'h5);
      queue_request(ple_pkg::KIND_LOCATE, 3, 32'h5);
      queue_request(KIND_RESERVED, 0, 32'h0);
      queue_request(ple_pkg::KIND_DELETE, 127, 32'h0);
      queue_request(ple_pkg::KIND_DELETE, 0, 32'h0);
      queue_request(ple_pkg::KIND_DELETE, 6, 32'h0);
      queue_request(ple_pkg::KIND_DELETE, 1, 32'hFFFF_FFFF);
      queue_request(ple_pkg::KIND_DELETE, 2, 32'h0);

      // Random phases: fill to capacity, drain to empty, or mixed traffic
      target = pending_reqs.size() + RANDOM_ITEMS;
      while (pending_reqs.size() < target) begin
         mode = phase_mode_type'($urandom_range(0, 2));
         tail_left = $urandom_range(2, 8);
         phase_items = $urandom_range(20, 120);
         case (mode)
            MODE_FILL: begin ins_pct = 70; del_pct = 10; end
            MODE_DRAIN: begin ins_pct = 15; del_pct = 65; end
            default: begin ins_pct = 40; del_pct = 35; end
         endcase
         done = 1'b0;
         while (!done) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               // noise: any kind, any position, any value
               r = $urandom_range(0, 3);
               kind = r[ple_pkg::KIND_W-1:0];
               pos = $urandom_range(0, 127);
               value = $urandom;
            end else begin
               r = $urandom_range(0, 99);
               value = pick_value();
               if (r < ins_pct) begin
                  kind = ple_pkg::KIND_INSERT;
                  r = $urandom_range(0, 99);
                  if (r < 15) pos = 1;
                  else if (r < 30) pos = gen_len + 1;
                  else if (r < 35) pos = $urandom_range(gen_len + 2, 127);
                  else pos = $urandom_range(1, gen_len + 1);
               end else if (r < ins_pct + del_pct) begin
                  kind = ple_pkg::KIND_DELETE;
                  pos = (gen_len == 0) ? $urandom_range(0, 127) : $urandom_range(1, gen_len);
               end else begin
                  kind = ple_pkg::KIND_LOCATE;
                  pos = $urandom_range(0, 127);
               end
            end
            queue_request(kind, pos, value);
            phase_items--;
            case (mode)
               MODE_FILL: if (gen_len == LIST_DEPTH) tail_left--;
               MODE_DRAIN: if (gen_len == 0) tail_left--;
               default: if (phase_items <= 0) tail_left = 0;
            endcase
            done = (tail_left <= 0) || (phase_items < -400) ||
                   (pending_reqs.size() >= target);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and answered, then let the block settle
      while (pending_reqs.size() > 0 || req_tvalid || predicted_results.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered: %0d insert, %0d delete, %0d locate, %0d reserved; peak length %0d",
               kind_count[ple_pkg::KIND_INSERT], kind_count[ple_pkg::KIND_DELETE],
               kind_count[ple_pkg::KIND_LOCATE], kind_count[KIND_RESERVED], peak_len);
      $display("responses checked %0d: ok %0d, range %0d, full %0d, missing %0d",
               results_checked, status_count[ple_pkg::STAT_OK],
               status_count[ple_pkg::STAT_RANGE], status_count[ple_pkg::STAT_FULL],
               status_count[ple_pkg::STAT_MISSING]);
      if (error_count == 0 && predicted_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Timeout watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, predicted_results.size());
      $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
src/ple_pkg.sv
src/ple_ram.sv
src/ple_ctrl.sv
src/ple_dp.sv
src/positional_list_engine_core.sv
sim/positional_list_engine_core_test.sv
